@@ design/assert_macros.svh @@
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define BBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by another one in the next cycle.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bba_pkg.sv @@
// Package with the types, codes and constants of the bitmap block allocator.
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_DATA_BLOCKS = 1024;
  localparam int unsigned MAX_INODES      = 256;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BIT_AW      = $clog2(WORD_W);
  localparam int unsigned DATA_WORDS  = MAX_DATA_BLOCKS / WORD_W;
  localparam int unsigned INODE_WORDS = MAX_INODES / WORD_W;
  localparam int unsigned MEM_WORDS   = DATA_WORDS + INODE_WORDS;
  localparam int unsigned MEM_AW      = $clog2(MEM_WORDS);
  localparam int unsigned WORD_AW     = $clog2(DATA_WORDS);
  localparam int unsigned INODE_BASE  = DATA_WORDS;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned ISIZE_W = 9;
  localparam int unsigned CFG_AW  = 2;

  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_FREE   = 1'b1;
  localparam logic POOL_DATA  = 1'b0;
  localparam logic POOL_INODE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_DATA_SIZE  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_INODE_SIZE = 2'd1;

  typedef struct packed {
    logic             cmd;
    logic             pool;
    logic [IDX_W-1:0] entry_index;
  } bba_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   granted_index;
    logic [COUNT_W-1:0] used_count;
  } bba_rsp_t;

  typedef struct packed {
    logic              re;
    logic [MEM_AW-1:0] raddr;
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [WORD_W-1:0] wdata;
  } bba_mem_req_t;

  function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_AW-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_AW'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

@@ design/bitmap_block_allocator_top.sv @@
// Top level of the first-fit bitmap allocator for the data block and inode pools.
//
// Usage: a request transaction is taken at a clock edge with start_i high and busy_o
// low. Its fields are cmd (allocate or free), pool (data or inode) and entry_index.
// Every request yields one result transaction: done_o is high for exactly one cycle
// while rsp_o holds status, granted_index and used_count. The receiver cannot stall.
// Allocate scans the pool bitmap one 32-bit word per cycle through the single memory
// read port and a priority encoder, from word 0 up to the word holding the granted
// bit, or through all words of the pool, 32 for a full 1024-entry data pool.
// Free reads one word; a free outside the pool size and an allocate on an
// empty-sized pool finish without reading the memory.
// busy_o is high while a request is being worked on; the next request may start in
// the cycle that done_o is high.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_wdata_i set the pool sizes and
// take effect at once; indexes beyond the two registers are ignored.
// Reset sets the pool sizes to their maxima, clears the used counts and clears the
// per-word valid bits, so both bitmaps read as all free right after reset.
`default_nettype none

module bitmap_block_allocator_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire bba_pkg::bba_req_t           req_i,
  output logic                             done_o,
  output bba_pkg::bba_rsp_t                rsp_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [bba_pkg::CFG_AW-1:0]  cfg_idx_i,
  input  wire logic [bba_pkg::COUNT_W-1:0] cfg_wdata_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  localparam int unsigned WA  = bba_pkg::WORD_AW;
  localparam int unsigned CW  = bba_pkg::COUNT_W;
  localparam int unsigned IW  = bba_pkg::ISIZE_W;
  localparam int unsigned BW  = bba_pkg::BIT_AW;
  localparam int unsigned WW  = bba_pkg::WORD_W;
  localparam int unsigned MAW = bba_pkg::MEM_AW;

  logic                state_q, state_d;
  logic [WA-1:0]       w_q, w_d;
  logic                cmd_q, cmd_d;
  logic                pool_q, pool_d;
  logic [BW-1:0]       bit_q, bit_d;
  logic [CW-1:0]       esize_q, esize_d;
  logic [CW-1:0]       data_used_q, data_used_d;
  logic [IW-1:0]       inode_used_q, inode_used_d;
  logic [CW-1:0]       data_size_q;
  logic [IW-1:0]       inode_size_q;
  logic                done_q, done_d;
  bba_pkg::bba_rsp_t   rsp_q, rsp_d;
  bba_pkg::bba_mem_req_t mem_req;
  logic [WW-1:0]       rdata;

  logic                accept;
  logic [CW-1:0]       esize_c;
  logic [CW-1:0]       used_c;
  logic [CW-1:0]       used_new_c;
  logic [CW-1:0]       rem_c;
  logic [WW-1:0]       vmask_c;
  logic [WW-1:0]       free_bits_c;
  logic [BW-1:0]       pos_c;
  logic [WA:0]         nxt_w_c;
  logic                more_c;

  function automatic logic [MAW-1:0] phys_addr(input logic pool, input logic [WA-1:0] w);
    logic [MAW-1:0] a;
    a = MAW'(w);
    if (pool == bba_pkg::POOL_INODE) begin
      a = MAW'(bba_pkg::INODE_BASE) + MAW'(w);
    end
    return a;
  endfunction

  bba_map_mem u_map_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(rdata)
  );

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_comb begin
    if (req_i.pool == bba_pkg::POOL_INODE) begin
      esize_c = (inode_size_q > IW'(bba_pkg::MAX_INODES)) ?
                CW'(bba_pkg::MAX_INODES) : CW'(inode_size_q);
    end else begin
      esize_c = (data_size_q > CW'(bba_pkg::MAX_DATA_BLOCKS)) ?
                CW'(bba_pkg::MAX_DATA_BLOCKS) : data_size_q;
    end
  end

  always_comb begin
    logic ipool;
    ipool  = (state_q == S_IDLE) ? req_i.pool : pool_q;
    used_c = (ipool == bba_pkg::POOL_INODE) ? CW'(inode_used_q) : data_used_q;
  end

  assign rem_c       = esize_q - CW'({w_q, {BW{1'b0}}});
  assign vmask_c     = (rem_c[CW-1:BW] != '0) ? '1 : ((WW'(1) << rem_c[BW-1:0]) - WW'(1));
  assign free_bits_c = ~rdata & vmask_c;
  assign pos_c       = bba_pkg::lowest_set(free_bits_c);
  assign nxt_w_c     = {1'b0, w_q} + (WA+1)'(1);
  assign more_c      = (CW'({nxt_w_c, {BW{1'b0}}}) < esize_q) && !nxt_w_c[WA];

  always_comb begin
    state_d      = state_q;
    w_d          = w_q;
    cmd_d        = cmd_q;
    pool_d       = pool_q;
    bit_d        = bit_q;
    esize_d      = esize_q;
    data_used_d  = data_used_q;
    inode_used_d = inode_used_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;
    used_new_c   = used_c;
    mem_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = req_i.cmd;
          pool_d  = req_i.pool;
          bit_d   = req_i.entry_index[BW-1:0];
          esize_d = esize_c;
          rsp_d.granted_index = '0;
          rsp_d.used_count    = used_c;
          if (req_i.cmd == bba_pkg::CMD_ALLOC) begin
            w_d = '0;
            if (esize_c == '0) begin
              done_d       = 1'b1;
              rsp_d.status = bba_pkg::ST_FULL;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = phys_addr(req_i.pool, '0);
              state_d       = S_EVAL;
            end
          end else begin
            w_d = req_i.entry_index[bba_pkg::IDX_W-1:BW];
            if (CW'(req_i.entry_index) >= esize_c) begin
              done_d       = 1'b1;
              rsp_d.status = bba_pkg::ST_RANGE;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = phys_addr(req_i.pool, req_i.entry_index[bba_pkg::IDX_W-1:BW]);
              state_d       = S_EVAL;
            end
          end
        end
      end
      S_EVAL: begin
        rsp_d.granted_index = '0;
        rsp_d.used_count    = used_c;
        if (cmd_q == bba_pkg::CMD_ALLOC) begin
          if (free_bits_c != '0) begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = phys_addr(pool_q, w_q);
            mem_req.wdata       = rdata | (WW'(1) << pos_c);
            used_new_c          = used_c + CW'(1);
            rsp_d.status        = bba_pkg::ST_OK;
            rsp_d.granted_index = {w_q, pos_c};
            rsp_d.used_count    = used_new_c;
            done_d              = 1'b1;
            state_d             = S_IDLE;
          end else if (more_c) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = phys_addr(pool_q, nxt_w_c[WA-1:0]);
            w_d           = nxt_w_c[WA-1:0];
          end else begin
            rsp_d.status = bba_pkg::ST_FULL;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          if (!rdata[bit_q]) begin
            rsp_d.status = bba_pkg::ST_FREE;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = phys_addr(pool_q, w_q);
            mem_req.wdata = rdata & ~(WW'(1) << bit_q);
            if (used_c != '0) begin
              used_new_c = used_c - CW'(1);
            end
            rsp_d.status     = bba_pkg::ST_OK;
            rsp_d.used_count = used_new_c;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
        if (pool_q == bba_pkg::POOL_INODE) begin
          inode_used_d = used_new_c[IW-1:0];
        end else begin
          data_used_d = used_new_c;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_q       <= 1'b0;
      data_used_q  <= '0;
      inode_used_q <= '0;
      data_size_q  <= CW'(bba_pkg::MAX_DATA_BLOCKS);
      inode_size_q <= IW'(bba_pkg::MAX_INODES);
    end else begin
      state_q      <= state_d;
      done_q       <= done_d;
      data_used_q  <= data_used_d;
      inode_used_q <= inode_used_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bba_pkg::CFG_DATA_SIZE:  data_size_q  <= cfg_wdata_i;
          bba_pkg::CFG_INODE_SIZE: inode_size_q <= cfg_wdata_i[IW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    cmd_q   <= cmd_d;
    pool_q  <= pool_d;
    bit_q   <= bit_d;
    esize_q <= esize_d;
    rsp_q   <= rsp_d;
  end

`include "assert_macros.svh"

  `BBA_ASSERT(a_done_not_busy, !(done_o && busy_o), "result shown while still busy")
  `BBA_ASSERT(a_data_count_max, data_used_q <= CW'(bba_pkg::MAX_DATA_BLOCKS), "data count overflow")
  `BBA_ASSERT(a_fail_no_grant, !(done_o && (rsp_o.status != bba_pkg::ST_OK)) || (rsp_o.granted_index == '0), "grant on failure")
  `BBA_ASSERT_NEXT(a_start_progress, start_i && !busy_o, busy_o || done_o, "accepted request made no progress")

endmodule

`default_nettype wire

@@ design/bba_map_mem.sv @@
// Bitmap word memory for both pools, with per-word valid bits that read as clear.
`default_nettype none

module bba_map_mem (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bba_pkg::bba_mem_req_t req_i,
  output logic [bba_pkg::WORD_W-1:0] rdata_o
);

  logic [bba_pkg::WORD_W-1:0]    mem [bba_pkg::MEM_WORDS];
  logic [bba_pkg::MEM_WORDS-1:0] row_vld_q;
  logic [bba_pkg::WORD_W-1:0]    rd_q;
  logic                          rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= row_vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire
